FILE: design/mvtt_pkg.sv
// ----------------------------------------------------------------------------
// mvtt_pkg
// Shared widths, operation and register codes, and the command and status
// structures used between the controller and the datapath of the tracker.
// ----------------------------------------------------------------------------
package mvtt_pkg;

  localparam int TIME_W        = 63;
  localparam int OP_W          = 3;
  localparam int CORE_W        = 3;
  localparam int CIU_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = TIME_W;
  localparam int NUM_CORES_DEF = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CIU_W-1:0]  CIU_RESET = 4'd8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LEAP        = 3'd0;
  localparam logic [OP_W-1:0] OP_SYNC_ALL    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_LEAST   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK_BLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_ACTIVATE    = 3'd4;
  localparam logic [OP_W-1:0] OP_DISABLE     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_GLOBAL = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORES_IN_USE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
    logic            rd_en;
    logic            exec;
    logic            wr;
    logic            fin;
    logic            gmin;
    logic            out_load;
  } mvtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic core_ok;
  } mvtt_sts_t;

  // Saturating add of two times.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

FILE: design/mvtt_in_if.sv
// ----------------------------------------------------------------------------
// mvtt_in_if
// Input channel: one operation item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvtt_in_if import mvtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CORE_W-1:0] core;
  logic [TIME_W-1:0] time_value;

  modport source(output valid, output op, output core, output time_value, input ready);
  modport sink(input valid, input op, input core, input time_value, output ready);
endinterface

FILE: design/mvtt_out_if.sv
// ----------------------------------------------------------------------------
// mvtt_out_if
// Result channel: one result item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvtt_out_if import mvtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] core_time;
  logic [TIME_W-1:0] global_time_out;
  logic              must_block;
  logic              none_active;

  modport source(output valid, output core_time, output global_time_out,
                 output must_block, output none_active, input ready);
  modport sink(input valid, input core_time, input global_time_out,
               input must_block, input none_active, output ready);
endinterface

FILE: design/mvtt_ram.sv
// ----------------------------------------------------------------------------
// mvtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mvtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/mvtt_ctrl.sv
// ----------------------------------------------------------------------------
// mvtt_ctrl
// Controller state machine: accepts an item, sweeps the core table, runs the
// update and write-back, optionally rescans for the active minimum, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module mvtt_ctrl import mvtt_pkg::*; #(
  parameter int AW = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  mvtt_sts_t       sts,
  input  logic [AW-1:0]   n_last,
  output mvtt_cmd_t       cmd,
  output logic [AW-1:0]   cnt
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SCAN       = 4'd1;
  localparam logic [3:0] S_SCAN_END   = 4'd2;
  localparam logic [3:0] S_EXEC       = 4'd3;
  localparam logic [3:0] S_WRITE      = 4'd4;
  localparam logic [3:0] S_RESCAN     = 4'd5;
  localparam logic [3:0] S_RESCAN_END = 4'd6;
  localparam logic [3:0] S_FINISH     = 4'd7;
  localparam logic [3:0] S_DELIVER    = 4'd8;

  logic [3:0]      state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            rescan;

  // In the minimum mode, ops that move the global time need a second sweep.
  assign rescan = sts.mode &&
                  (op_r == OP_SYNC_ALL || op_r == OP_ADD_LEAST ||
                   op_r == OP_READ_GLOBAL ||
                   ((op_r == OP_LEAP || op_r == OP_ACTIVATE) && sts.core_ok));

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN, S_RESCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == n_last) begin
          state_nxt = (state_r == S_SCAN) ? S_SCAN_END : S_RESCAN_END;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_SCAN_END: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (op_r == OP_SYNC_ALL && cnt_r != n_last) begin
          cnt_nxt = cnt_r + AW'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = rescan ? S_RESCAN : S_FINISH;
        end
      end
      S_RESCAN_END: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.fin   = 1'b1;
        cmd.gmin  = rescan;
        state_nxt = S_DELIVER;
      end
      S_DELIVER: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      op_r        <= OP_LEAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

endmodule

FILE: design/mvtt_dp.sv
// ----------------------------------------------------------------------------
// mvtt_dp
// Datapath: configuration registers, core time table with valid bits, active
// flags, global time, sweep accumulators, update arithmetic and the output
// register.
// ----------------------------------------------------------------------------
module mvtt_dp import mvtt_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF,
  parameter int AW        = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mvtt_cmd_t            cmd,
  input  logic [AW-1:0]        cnt,
  output mvtt_sts_t            sts,
  output logic [AW-1:0]        n_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [CORE_W-1:0]    in_core,
  input  logic [TIME_W-1:0]    in_time,
  output logic [TIME_W-1:0]    out_core_time,
  output logic [TIME_W-1:0]    out_global_time,
  output logic                 out_must_block,
  output logic                 out_none_active
);

  localparam int NW = $clog2(NUM_CORES + 1);
  localparam int EW = (NW > CIU_W) ? NW : CIU_W;
  localparam int XW = (AW > CORE_W) ? AW : CORE_W;
  localparam logic [EW-1:0] NC_X = EW'(NUM_CORES);

  // Configuration registers.
  logic              mode_r;
  logic [TIME_W-1:0] margin_r;
  logic [CIU_W-1:0]  ciu_r;

  // Latched item payload.
  logic [CORE_W-1:0] core_r;
  logic [TIME_W-1:0] tv_r;

  // Table, flags and global time.
  logic [NUM_CORES-1:0] valid_r;
  logic [NUM_CORES-1:0] active_r;
  logic [TIME_W-1:0]    global_r;

  // Read pipeline and sweep accumulators.
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [TIME_W-1:0] ram_q;
  logic [TIME_W-1:0] max_r, min_r, cval_r, amin_r;
  logic [AW-1:0]     min_idx_r;
  logic              afound_r;

  // Update results.
  logic [TIME_W-1:0] res_r, ct_r, diff_r;
  logic              gt_r, ahead_r, blk_r;

  // Output register.
  logic [TIME_W-1:0] out_ct_r, out_gt_r;
  logic              out_blk_r, out_none_r;

  logic [EW-1:0]        ciu_x, n_x, n_last_x, core_x;
  logic [XW-1:0]        core_w;
  logic [AW-1:0]        core_a;
  logic                 core_ok;
  logic [NUM_CORES-1:0] inuse;
  logic                 any_act;
  logic [TIME_W-1:0]    rd_val, res_nxt, ct_nxt, gup_val;
  logic                 first, afound_base, ahead_c, gup;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic                 is_lp_act;

  // Effective core count, addressed core and in-use mask.
  always_comb begin
    ciu_x    = EW'(ciu_r);
    n_x      = (ciu_x == '0) ? EW'(1) : ((ciu_x > NC_X) ? NC_X : ciu_x);
    n_last_x = n_x - EW'(1);
    core_x   = EW'(core_r);
    core_w   = XW'(core_r);
    core_a   = core_w[AW-1:0];
    core_ok  = core_x < n_x;
    for (int i = 0; i < NUM_CORES; i++) begin
      inuse[i] = EW'(i) < n_x;
    end
    any_act = |(active_r & inuse);
  end

  assign n_last      = n_last_x[AW-1:0];
  assign sts.mode    = mode_r;
  assign sts.core_ok = core_ok;

  // Core time table; entries not yet written read as zero.
  mvtt_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_CORES),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (we),
    .wr_addr(waddr),
    .wr_data(res_r),
    .rd_en  (cmd.rd_en),
    .rd_addr(cnt),
    .rd_data(ram_q)
  );

  assign rd_val      = valid_r[rd_idx_r] ? ram_q : '0;
  assign first       = (rd_idx_r == '0);
  assign afound_base = first ? 1'b0 : afound_r;

  // Update value and reported core time.
  always_comb begin
    case (cmd.op)
      OP_LEAP, OP_ACTIVATE: res_nxt = (cval_r < tv_r) ? tv_r : cval_r;
      OP_SYNC_ALL:          res_nxt = sat_add(max_r, tv_r);
      OP_ADD_LEAST:         res_nxt = sat_add(min_r, tv_r);
      default:              res_nxt = cval_r;
    endcase
    case (cmd.op)
      OP_SYNC_ALL, OP_ADD_LEAST: ct_nxt = res_nxt;
      OP_CLEAR:                  ct_nxt = '0;
      default:                   ct_nxt = core_ok ? res_nxt : '0;
    endcase
  end

  // Write-back controls and plain-mode global update.
  assign is_lp_act = (cmd.op == OP_LEAP || cmd.op == OP_ACTIVATE) && core_ok;
  assign we        = cmd.wr &&
                     (is_lp_act || cmd.op == OP_SYNC_ALL || cmd.op == OP_ADD_LEAST);
  assign waddr     = (cmd.op == OP_SYNC_ALL) ? cnt :
                     ((cmd.op == OP_ADD_LEAST) ? min_idx_r : core_a);
  assign gup       = !mode_r && cmd.wr &&
                     (is_lp_act || cmd.op == OP_SYNC_ALL || cmd.op == OP_ADD_LEAST);
  assign gup_val   = (cmd.op == OP_ACTIVATE) ? tv_r : res_r;
  assign ahead_c   = gt_r && (diff_r > margin_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      margin_r <= '0;
      ciu_r    <= CIU_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GLOBAL_MODE:  mode_r   <= cfg_data[0];
        REG_BLOCK_MARGIN: margin_r <= cfg_data;
        REG_CORES_IN_USE: ciu_r    <= cfg_data[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Table valid bits, active flags and global time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
      global_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.wr && cmd.op == OP_CLEAR) begin
        valid_r  <= '0;
        active_r <= '0;
        global_r <= '0;
      end else begin
        if (we) begin
          valid_r[waddr] <= 1'b1;
        end
        if (cmd.wr && mode_r && core_ok) begin
          if (cmd.op == OP_ACTIVATE) begin
            active_r[core_a] <= 1'b1;
          end else if (cmd.op == OP_DISABLE ||
                       (cmd.op == OP_CHECK_BLOCK && ahead_c)) begin
            active_r[core_a] <= 1'b0;
          end
        end
        if (gup && global_r < gup_val) begin
          global_r <= gup_val;
        end else if (cmd.fin && cmd.gmin && afound_r) begin
          global_r <= amin_r;
        end
      end
    end
  end

  // Payload latch, sweep accumulators and update pipeline.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      core_r <= in_core;
      tv_r   <= in_time;
    end
    rd_idx_r <= cnt;
    if (rd_vld_r) begin
      if (first || rd_val > max_r) begin
        max_r <= rd_val;
      end
      if (first || rd_val < min_r) begin
        min_r     <= rd_val;
        min_idx_r <= rd_idx_r;
      end
      if (rd_idx_r == core_a) begin
        cval_r <= rd_val;
      end
      if (active_r[rd_idx_r] && (!afound_base || rd_val < amin_r)) begin
        amin_r   <= rd_val;
        afound_r <= 1'b1;
      end else begin
        afound_r <= afound_base;
      end
    end
    if (cmd.exec) begin
      res_r  <= res_nxt;
      ct_r   <= ct_nxt;
      gt_r   <= cval_r > global_r;
      diff_r <= cval_r - global_r;
    end
    if (cmd.wr) begin
      ahead_r <= ahead_c;
    end
    if (cmd.fin) begin
      blk_r <= (cmd.op == OP_CHECK_BLOCK) && core_ok && ahead_r &&
               (!mode_r || any_act);
    end
    if (cmd.out_load) begin
      out_ct_r   <= ct_r;
      out_gt_r   <= global_r;
      out_blk_r  <= blk_r;
      out_none_r <= !any_act;
    end
  end

  assign out_core_time   = out_ct_r;
  assign out_global_time = out_gt_r;
  assign out_must_block  = out_blk_r;
  assign out_none_active = out_none_r;

endmodule

FILE: design/multicore_virtual_time_tracker.sv
// ----------------------------------------------------------------------------
// multicore_virtual_time_tracker
// Per-core virtual time tracker with a global time in running-maximum or
// active-minimum mode.
// ----------------------------------------------------------------------------
// One item is handled at a time. With n the effective cores_in_use, most
// operations sweep n table reads through the single read port of the core
// time RAM, then run update, write-back and finish steps before the result
// is loaded; sync all writes the new time to every in-use core, and in
// minimum mode the operations that move the global time add a second sweep.
// The result sits in an output register, so a new item is accepted while it
// waits. Core times reset to zero through per-entry valid bits; no clearing
// pass is needed after reset, and the clear operation follows the same steps
// as most operations.
// ----------------------------------------------------------------------------
module multicore_virtual_time_tracker import mvtt_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mvtt_in_if.sink              in_ch,
  mvtt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  mvtt_cmd_t     cmd;
  mvtt_sts_t     sts;
  logic [AW-1:0] cnt;
  logic [AW-1:0] n_last;

  // Sequencer.
  mvtt_ctrl #(
    .AW(AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .sts      (sts),
    .n_last   (n_last),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  // Table, flags, arithmetic and output register.
  mvtt_dp #(
    .NUM_CORES(NUM_CORES),
    .AW       (AW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cnt            (cnt),
    .sts            (sts),
    .n_last         (n_last),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_core        (in_ch.core),
    .in_time        (in_ch.time_value),
    .out_core_time  (out_ch.core_time),
    .out_global_time(out_ch.global_time_out),
    .out_must_block (out_ch.must_block),
    .out_none_active(out_ch.none_active)
  );

endmodule
